// ===== hdl/lsi_pkg.sv =====
// shared constants and state types of the leverage surface interpolator
`default_nettype none
package lsi_pkg;
    localparam int MAX_LAYERS_DEF = 64;
    localparam int MAX_POINTS_DEF = 256;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [31:0] ONE_Q24 = 32'h0100_0000;
    localparam logic [29:0] LN2_Q30 = 30'd744261118;

    localparam int LN_W  = 29;
    localparam int DIV_W = 57;
    localparam int F_W   = 60;

    typedef enum logic [3:0] {
        S_IDLE, S_T0, S_TN, S_SRCH, S_LN, S_LRD, S_LDIV, S_LF,
        S_LV0, S_LV1, S_LBL, S_TDIV, S_TBL, S_DONE
    } state_t;

    typedef enum logic [2:0] {
        LN_IDLE, LN_NORM, LN_SQ, LN_ABS, LN_MUL, LN_RND
    } ln_state_t;
endpackage
`default_nettype wire

// ===== hdl/lsi_if.sv =====
// command and response channel interfaces
`default_nettype none
interface lsi_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [31:0]       time_value;
    logic [31:0]       log_step;
    logic signed [15:0] grid_offset;
    logic [31:0]       level_value;
    logic [47:0]       spot;

    modport source(output valid, op, time_value, log_step, grid_offset, level_value, spot,
                   input ready);
    modport sink(input valid, op, time_value, log_step, grid_offset, level_value, spot,
                 output ready);
endinterface

interface lsi_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] leverage;
    logic [1:0]  status;

    modport source(output valid, leverage, status, input ready);
    modport sink(input valid, leverage, status, output ready);
endinterface
`default_nettype wire

// ===== hdl/lsi_div.sv =====
// restoring divider, one quotient bit per cycle
`default_nettype none
module lsi_div #(
    parameter int NW = lsi_pkg::DIV_W,
    parameter int DW = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               done,
    output logic [NW-1:0]      quo,
    output logic               rem_nz
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] num_reg, num_next;
    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg, den_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [DW:0]   r2;

    always_comb
    begin
        num_next  = num_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        r2        = {rem_reg, num_reg[NW-1]};
        if (start)
        begin
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            q_next    = '0;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = num_reg << 1;
            if (r2 >= {1'b0, den_reg})
            begin
                rem_next = DW'(r2 - {1'b0, den_reg});
                q_next   = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next = DW'(r2);
                q_next   = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done   = done_reg;
    assign quo    = q_reg;
    assign rem_nz = |rem_reg;
endmodule
`default_nettype wire

// ===== hdl/lsi_ln.sv =====
// natural log of a q24.24 value by normalize and repeated squaring
`default_nettype none
module lsi_ln (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic [47:0]            m,
    output logic                        done,
    output logic                        neg,
    output logic [lsi_pkg::LN_W-1:0]    mag
);
    lsi_pkg::ln_state_t st_reg, st_next;
    logic [47:0]  x48_reg, x48_next;
    logic [5:0]   e_reg, e_next;
    logic [28:0]  x_reg, x_next;
    logic [27:0]  frac_reg, frac_next;
    logic [4:0]   k_reg, k_next;
    logic         sgn_reg, sgn_next;
    logic [32:0]  l2m_reg, l2m_next;
    logic [62:0]  prod_reg, prod_next;
    logic [lsi_pkg::LN_W-1:0] res_reg, res_next;
    logic         done_reg, done_next;
    logic [57:0]  sq;
    logic [29:0]  s;
    logic signed [6:0]  ediff;
    logic signed [35:0] l2;
    logic [62:0]  rnd;

    always_comb
    begin
        st_next   = st_reg;
        x48_next  = x48_reg;
        e_next    = e_reg;
        x_next    = x_reg;
        frac_next = frac_reg;
        k_next    = k_reg;
        sgn_next  = sgn_reg;
        l2m_next  = l2m_reg;
        prod_next = prod_reg;
        res_next  = res_reg;
        done_next = done_reg;
        sq        = 58'(x_reg) * 58'(x_reg);
        s         = sq[57:28];
        ediff     = $signed({1'b0, e_reg}) - 7'sd24;
        l2        = $signed(36'({{29{ediff[6]}}, ediff}) << 28) + $signed(36'(frac_reg));
        rnd       = prod_reg + (63'(1) << 33);
        case (st_reg)
            lsi_pkg::LN_IDLE:
            begin
                if (start)
                begin
                    x48_next  = m;
                    e_next    = 6'd47;
                    done_next = 1'b0;
                    st_next   = lsi_pkg::LN_NORM;
                end
            end
            lsi_pkg::LN_NORM:
            begin
                if (x48_reg[47])
                begin
                    x_next    = x48_reg[47:19];
                    frac_next = '0;
                    k_next    = '0;
                    st_next   = lsi_pkg::LN_SQ;
                end
                else
                begin
                    x48_next = x48_reg << 1;
                    e_next   = e_reg - 1'b1;
                end
            end
            lsi_pkg::LN_SQ:
            begin
                if (s[29])
                begin
                    x_next    = s[29:1];
                    frac_next = {frac_reg[26:0], 1'b1};
                end
                else
                begin
                    x_next    = s[28:0];
                    frac_next = {frac_reg[26:0], 1'b0};
                end
                k_next = k_reg + 1'b1;
                if (k_reg == 5'd27)
                begin
                    st_next = lsi_pkg::LN_ABS;
                end
            end
            lsi_pkg::LN_ABS:
            begin
                sgn_next = l2[35];
                l2m_next = l2[35] ? 33'(-l2) : 33'(l2);
                st_next  = lsi_pkg::LN_MUL;
            end
            lsi_pkg::LN_MUL:
            begin
                prod_next = 63'(l2m_reg) * 63'(lsi_pkg::LN2_Q30);
                st_next   = lsi_pkg::LN_RND;
            end
            lsi_pkg::LN_RND:
            begin
                res_next  = rnd[34 +: lsi_pkg::LN_W];
                done_next = 1'b1;
                st_next   = lsi_pkg::LN_IDLE;
            end
            default:
            begin
                st_next = lsi_pkg::LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= lsi_pkg::LN_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x48_reg  <= x48_next;
        e_reg    <= e_next;
        x_reg    <= x_next;
        frac_reg <= frac_next;
        k_reg    <= k_next;
        sgn_reg  <= sgn_next;
        l2m_reg  <= l2m_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
    end

    assign done = done_reg;
    assign neg  = sgn_reg && (res_reg != '0);
    assign mag  = res_reg;
endmodule
`default_nettype wire

// ===== hdl/lsi_blend.sv =====
// linear blend of two q8.24 levels by a 25-bit weight
`default_nettype none
module lsi_blend (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    input  wire logic [24:0] w,
    output logic             done,
    output logic [31:0]      y
);
    logic        v1_reg, v2_reg, v3_reg;
    logic [56:0] p_reg, p_next;
    logic [56:0] acc_reg, acc_next;
    logic [31:0] b_reg;
    logic [24:0] w_reg;
    logic [31:0] y_reg, y_next;
    logic [56:0] rnd;

    always_comb
    begin
        p_next   = 57'(25'h100_0000 - w) * 57'(a);
        acc_next = p_reg + 57'(w_reg) * 57'(b_reg);
        rnd      = acc_reg + (57'(1) << 23);
        y_next   = rnd[55:24];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            p_reg <= p_next;
            b_reg <= b;
            w_reg <= w;
        end
        acc_reg <= acc_next;
        y_reg   <= y_next;
    end

    assign done = v3_reg;
    assign y    = y_reg;
endmodule
`default_nettype wire

// ===== hdl/leverage_surface_interpolator.sv =====
// leverage surface interpolator top level: layer and level memories with query sequencer
// loads (start layer, append level) go straight to the done state and from there to the output register
// a query runs the log unit at most once and the divider up to three times
// (the layer walk compares one layer time per cycle)
// one item at a time; the next command is taken once the result sits in the output register
// reset clears the layer count and control; the memories are not cleared and need no sweep
`default_nettype none
module leverage_surface_interpolator #(
    parameter int MAX_LAYERS = lsi_pkg::MAX_LAYERS_DEF,
    parameter int MAX_POINTS = lsi_pkg::MAX_POINTS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lsi_in_if.sink     cmd,
    lsi_out_if.source  rsp
);
    localparam int LIW   = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
    localparam int LCW   = $clog2(MAX_LAYERS + 1);
    localparam int PIW   = $clog2(MAX_POINTS);
    localparam int PCW   = $clog2(MAX_POINTS + 1);
    localparam int LVD   = MAX_LAYERS * MAX_POINTS;
    localparam int LVAW  = $clog2(LVD);
    localparam int FW    = lsi_pkg::F_W;
    localparam int NW    = lsi_pkg::DIV_W;

    typedef struct packed {
        logic [31:0]    tm;
        logic [31:0]    step;
        logic [15:0]    off;
        logic [PCW-1:0] pcnt;
    } layer_t;

    layer_t      lt_mem [MAX_LAYERS];
    logic [31:0] lv_mem [LVD];

    layer_t           lt_rd, lt_wd;
    logic [LIW-1:0]   lt_raddr, lt_waddr;
    logic             lt_we;
    logic [31:0]      lv_rd, lv_wd;
    logic [LVAW-1:0]  lv_raddr, lv_waddr;
    logic             lv_we;

    lsi_pkg::state_t  state_reg, state_next;
    logic [LCW-1:0]   cnt_reg, cnt_next;
    layer_t           last_reg, last_next;
    logic [31:0]      t_reg, t_next;
    logic [47:0]      spot_reg, spot_next;
    logic             single_reg, single_next;
    logic             phase_reg, phase_next;
    logic [LIW-1:0]   hi_reg, hi_next;
    logic [LIW-1:0]   cur_reg, cur_next;
    logic [LIW-1:0]   khi_reg, khi_next;
    logic [31:0]      tlo_reg, tlo_next;
    logic [31:0]      thi_reg, thi_next;
    logic [15:0]      off_reg, off_next;
    logic [PCW-1:0]   pcnt_reg, pcnt_next;
    logic signed [FW-1:0] f_reg, f_next;
    logic [PIW-1:0]   idx_reg, idx_next;
    logic [24:0]      w_reg, w_next;
    logic             pick_reg, pick_next;
    logic [31:0]      a_reg, a_next;
    logic [31:0]      vlo_reg, vlo_next;
    logic [31:0]      res_reg, res_next;
    logic [1:0]       rst_reg, rst_next;
    logic [31:0]      olev_reg, olev_next;
    logic [1:0]       ost_reg, ost_next;
    logic             ov_reg, ov_next;

    logic             ln_start, ln_done, ln_neg;
    logic [lsi_pkg::LN_W-1:0] ln_mag;
    logic             div_start, div_done, div_rnz;
    logic [NW-1:0]    div_num, div_q;
    logic [31:0]      div_den;
    logic             bl_start, bl_done;
    logic [31:0]      bl_a, bl_b, bl_y;
    logic [24:0]      bl_w;

    logic             lend;
    logic [31:0]      lval;
    logic [LVAW-1:0]  lv_base, app_base;
    logic signed [FW-1:0] qs, offs, lim;
    logic [LCW-1:0]   n_m1;

    lsi_ln u_ln (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ln_start),
        .m     (cmd.spot),
        .done  (ln_done),
        .neg   (ln_neg),
        .mag   (ln_mag)
    );

    lsi_div #(.NW(NW), .DW(32)) u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num    (div_num),
        .den    (div_den),
        .done   (div_done),
        .quo    (div_q),
        .rem_nz (div_rnz)
    );

    lsi_blend u_blend (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bl_start),
        .a     (bl_a),
        .b     (bl_b),
        .w     (bl_w),
        .done  (bl_done),
        .y     (bl_y)
    );

    always_ff @(posedge clk)
    begin
        if (lt_we)
        begin
            lt_mem[lt_waddr] <= lt_wd;
        end
        lt_rd <= lt_mem[lt_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (lv_we)
        begin
            lv_mem[lv_waddr] <= lv_wd;
        end
        lv_rd <= lv_mem[lv_raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        last_next   = last_reg;
        t_next      = t_reg;
        spot_next   = spot_reg;
        single_next = single_reg;
        phase_next  = phase_reg;
        hi_next     = hi_reg;
        cur_next    = cur_reg;
        khi_next    = khi_reg;
        tlo_next    = tlo_reg;
        thi_next    = thi_reg;
        off_next    = off_reg;
        pcnt_next   = pcnt_reg;
        f_next      = f_reg;
        idx_next    = idx_reg;
        w_next      = w_reg;
        pick_next   = pick_reg;
        a_next      = a_reg;
        vlo_next    = vlo_reg;
        res_next    = res_reg;
        rst_next    = rst_reg;
        olev_next   = olev_reg;
        ost_next    = ost_reg;
        ov_next     = ov_reg && !rsp.ready;

        cmd.ready = 1'b0;
        lt_we     = 1'b0;
        lt_waddr  = '0;
        lt_wd     = last_reg;
        lt_raddr  = cur_reg;
        lv_we     = 1'b0;
        lv_wd     = cmd.level_value;
        ln_start  = 1'b0;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        bl_start  = 1'b0;
        bl_a      = a_reg;
        bl_b      = lv_rd;
        bl_w      = w_reg;
        lend      = 1'b0;
        lval      = lv_rd;

        n_m1     = cnt_reg - 1'b1;
        lv_base  = LVAW'(cur_reg) * LVAW'(MAX_POINTS);
        app_base = LVAW'(LIW'(n_m1)) * LVAW'(MAX_POINTS);
        lv_waddr = app_base + LVAW'(last_reg.pcnt[PIW-1:0]);
        lv_raddr = lv_base + LVAW'(idx_reg);
        qs       = ln_neg ? -$signed(FW'(div_q) + FW'(div_rnz)) : $signed(FW'(div_q));
        offs     = $signed({{(FW-16){off_reg[15]}}, off_reg}) <<< 24;
        lim      = $signed(FW'(pcnt_reg - 1'b1)) <<< 24;

        case (state_reg)
            lsi_pkg::S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    res_next   = '0;
                    rst_next   = lsi_pkg::ST_OK;
                    state_next = lsi_pkg::S_DONE;
                    case (cmd.op)
                        lsi_pkg::OP_START:
                        begin
                            if (cnt_reg >= LCW'(MAX_LAYERS) || cmd.log_step == '0)
                            begin
                                rst_next = lsi_pkg::ST_REJECT;
                            end
                            else
                            begin
                                last_next.tm   = cmd.time_value;
                                last_next.step = cmd.log_step;
                                last_next.off  = cmd.grid_offset;
                                last_next.pcnt = '0;
                                lt_we          = 1'b1;
                                lt_waddr       = LIW'(cnt_reg);
                                lt_wd          = last_next;
                                cnt_next       = cnt_reg + 1'b1;
                            end
                        end
                        lsi_pkg::OP_APPEND:
                        begin
                            if (cnt_reg == '0 || last_reg.pcnt >= PCW'(MAX_POINTS))
                            begin
                                rst_next = lsi_pkg::ST_REJECT;
                            end
                            else
                            begin
                                lv_we          = 1'b1;
                                last_next.pcnt = last_reg.pcnt + 1'b1;
                                lt_we          = 1'b1;
                                lt_waddr       = LIW'(n_m1);
                                lt_wd          = last_next;
                            end
                        end
                        lsi_pkg::OP_QUERY:
                        begin
                            t_next    = cmd.time_value;
                            spot_next = cmd.spot;
                            phase_next = 1'b0;
                            if (cnt_reg == '0)
                            begin
                                res_next = lsi_pkg::ONE_Q24;
                            end
                            else
                            begin
                                ln_start   = (cmd.spot != '0);
                                lt_raddr   = '0;
                                state_next = lsi_pkg::S_T0;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            lsi_pkg::S_T0:
            begin
                if (t_reg <= lt_rd.tm)
                begin
                    cur_next    = '0;
                    single_next = 1'b1;
                    state_next  = lsi_pkg::S_LN;
                end
                else
                begin
                    lt_raddr   = LIW'(n_m1);
                    state_next = lsi_pkg::S_TN;
                end
            end
            lsi_pkg::S_TN:
            begin
                if (t_reg >= lt_rd.tm)
                begin
                    cur_next    = LIW'(n_m1);
                    single_next = 1'b1;
                    state_next  = lsi_pkg::S_LN;
                end
                else
                begin
                    hi_next    = LIW'(1);
                    lt_raddr   = LIW'(1);
                    state_next = lsi_pkg::S_SRCH;
                end
            end
            lsi_pkg::S_SRCH:
            begin
                if (LCW'(hi_reg) < n_m1 && lt_rd.tm < t_reg)
                begin
                    hi_next  = hi_reg + 1'b1;
                    lt_raddr = hi_reg + 1'b1;
                end
                else
                begin
                    cur_next    = hi_reg - 1'b1;
                    khi_next    = hi_reg;
                    thi_next    = lt_rd.tm;
                    single_next = 1'b0;
                    state_next  = lsi_pkg::S_LN;
                end
            end
            lsi_pkg::S_LN:
            begin
                if (spot_reg == '0 || ln_done)
                begin
                    lt_raddr   = cur_reg;
                    state_next = lsi_pkg::S_LRD;
                end
            end
            lsi_pkg::S_LRD:
            begin
                off_next  = lt_rd.off;
                pcnt_next = lt_rd.pcnt;
                if (!phase_reg)
                begin
                    tlo_next = lt_rd.tm;
                end
                if (lt_rd.pcnt == '0)
                begin
                    res_next   = '0;
                    rst_next   = lsi_pkg::ST_EMPTY;
                    state_next = lsi_pkg::S_DONE;
                end
                else if (spot_reg == '0)
                begin
                    idx_next   = '0;
                    pick_next  = 1'b1;
                    lv_raddr   = lv_base;
                    state_next = lsi_pkg::S_LV0;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = NW'({ln_mag, 28'b0});
                    div_den    = lt_rd.step;
                    state_next = lsi_pkg::S_LDIV;
                end
            end
            lsi_pkg::S_LDIV:
            begin
                if (div_done)
                begin
                    f_next     = qs - offs;
                    state_next = lsi_pkg::S_LF;
                end
            end
            lsi_pkg::S_LF:
            begin
                if (f_reg <= 0)
                begin
                    idx_next  = '0;
                    pick_next = 1'b1;
                end
                else if (f_reg >= lim)
                begin
                    idx_next  = PIW'(pcnt_reg - 1'b1);
                    pick_next = 1'b1;
                end
                else
                begin
                    idx_next  = f_reg[24 +: PIW];
                    w_next    = {1'b0, f_reg[23:0]};
                    pick_next = 1'b0;
                end
                lv_raddr   = lv_base + LVAW'(idx_next);
                state_next = lsi_pkg::S_LV0;
            end
            lsi_pkg::S_LV0:
            begin
                a_next = lv_rd;
                if (pick_reg)
                begin
                    lend = 1'b1;
                    lval = lv_rd;
                end
                else
                begin
                    lv_raddr   = lv_base + LVAW'(idx_reg) + LVAW'(1);
                    state_next = lsi_pkg::S_LV1;
                end
            end
            lsi_pkg::S_LV1:
            begin
                bl_start   = 1'b1;
                state_next = lsi_pkg::S_LBL;
            end
            lsi_pkg::S_LBL:
            begin
                if (bl_done)
                begin
                    lend = 1'b1;
                    lval = bl_y;
                end
            end
            lsi_pkg::S_TDIV:
            begin
                if (div_done)
                begin
                    bl_start   = 1'b1;
                    bl_a       = vlo_reg;
                    bl_b       = a_reg;
                    bl_w       = div_q[24:0];
                    state_next = lsi_pkg::S_TBL;
                end
            end
            lsi_pkg::S_TBL:
            begin
                if (bl_done)
                begin
                    res_next   = bl_y;
                    state_next = lsi_pkg::S_DONE;
                end
            end
            lsi_pkg::S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    olev_next  = res_reg;
                    ost_next   = rst_reg;
                    state_next = lsi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lsi_pkg::S_IDLE;
            end
        endcase

        if (lend)
        begin
            if (single_reg)
            begin
                res_next   = lval;
                state_next = lsi_pkg::S_DONE;
            end
            else if (!phase_reg)
            begin
                vlo_next   = lval;
                phase_next = 1'b1;
                cur_next   = khi_reg;
                state_next = lsi_pkg::S_LN;
            end
            else
            begin
                a_next     = lval;
                div_start  = 1'b1;
                div_num    = NW'({t_reg - tlo_reg, 24'b0});
                div_den    = thi_reg - tlo_reg;
                state_next = lsi_pkg::S_TDIV;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsi_pkg::S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            last_reg  <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        spot_reg   <= spot_next;
        single_reg <= single_next;
        phase_reg  <= phase_next;
        hi_reg     <= hi_next;
        cur_reg    <= cur_next;
        khi_reg    <= khi_next;
        tlo_reg    <= tlo_next;
        thi_reg    <= thi_next;
        off_reg    <= off_next;
        pcnt_reg   <= pcnt_next;
        f_reg      <= f_next;
        idx_reg    <= idx_next;
        w_reg      <= w_next;
        pick_reg   <= pick_next;
        a_reg      <= a_next;
        vlo_reg    <= vlo_next;
        res_reg    <= res_next;
        rst_reg    <= rst_next;
        olev_reg   <= olev_next;
        ost_reg    <= ost_next;
    end

    assign rsp.valid    = ov_reg;
    assign rsp.leverage = olev_reg;
    assign rsp.status   = ost_reg;

    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= LCW'(MAX_LAYERS))
        else $error("layer count above table size");

    a_pts_max: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg.pcnt <= PCW'(MAX_POINTS))
        else $error("point count above layer size");

    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.op != lsi_pkg::OP_QUERY) |=> state_reg == lsi_pkg::S_DONE)
        else $error("load did not go straight to result");

    a_pair_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lsi_pkg::S_LV1) |-> (PCW'(idx_reg) + PCW'(1) < pcnt_reg))
        else $error("blend pair beyond last point");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status == lsi_pkg::ST_EMPTY) |-> rsp.leverage == '0)
        else $error("empty layer result not zero");
endmodule
`default_nettype wire
